// ===== rtl/sfc_pkg.sv =====
package sfc_pkg;

  localparam int FRAME_BYTES = 39;
  localparam int STORE_DEPTH = 18;
  localparam int RAW_WORDS   = (FRAME_BYTES - 3) / 2;
  localparam int WORD_COUNT  = (RAW_WORDS < STORE_DEPTH) ? RAW_WORDS : STORE_DEPTH;

  localparam int BYTE_W = 8;
  localparam int WORD_W = 16;
  localparam int IDX_W  = 5;
  localparam int POS_W  = 6;
  localparam int CODE_W = 2;

  localparam logic [POS_W-1:0]  LAST_POS   = POS_W'(FRAME_BYTES - 1);
  localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(WORD_COUNT - 1);
  localparam logic [IDX_W-1:0]  STORE_LIM  = IDX_W'(STORE_DEPTH);
  localparam logic [BYTE_W-1:0] HEAD_BYTE0 = 8'hFF;
  localparam logic [BYTE_W-1:0] HEAD_BYTE1 = 8'hFA;

  localparam int FAN_BIT       = 3;
  localparam int FAN_SPEED_BIT = 2;

  localparam logic [CODE_W-1:0] ST_OK         = 2'd0;
  localparam logic [CODE_W-1:0] ST_BAD_HEADER = 2'd1;
  localparam logic [CODE_W-1:0] ST_BAD_SUM    = 2'd2;

  typedef struct packed {
    logic              shift;
    logic [WORD_W-1:0] word;
  } chain_ctl_t;

endpackage

// ===== rtl/sfc_cell.sv =====
module sfc_cell
  import sfc_pkg::*;
(
  input  logic              clk,
  input  logic              shift,
  input  logic [WORD_W-1:0] d,
  output logic [WORD_W-1:0] q
);

  logic [WORD_W-1:0] word_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      word_r <= d;
    end
  end

  assign q = word_r;

endmodule

// ===== rtl/sfc_chain.sv =====
module sfc_chain
  import sfc_pkg::*;
(
  input  logic              clk,
  input  chain_ctl_t        ctl,
  output logic [WORD_W-1:0] head
);

  logic [WORD_W-1:0] q [WORD_COUNT];

  // words enter at the tail and move one cell toward the head per shift
  for (genvar i = 0; i < WORD_COUNT; i++) begin : g_cell
    logic [WORD_W-1:0] d;
    if (i == WORD_COUNT - 1) begin : g_tail
      assign d = ctl.word;
    end else begin : g_mid
      assign d = q[i+1];
    end
    sfc_cell u_cell (
      .clk   (clk),
      .shift (ctl.shift),
      .d     (d),
      .q     (q[i])
    );
  end

  assign head = q[0];

endmodule

// ===== rtl/sensor_frame_checker.sv =====
// one byte transaction per cycle while busy is low; bytes other than the last give no result
// last byte: an error result in the next cycle, or WORD_COUNT word results on consecutive
// cycles, the first once emitting_r is set and the head word is registered to the outputs
// busy is high while the word chain shifts out after a good frame
// the receiver cannot stall: out_valid marks each result for exactly one cycle
// synchronous active-low reset returns to waiting for a frame start, no result pending
module sensor_frame_checker
  import sfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [BYTE_W-1:0] in_rx_byte,
  input  logic              in_frame_start,
  output logic              out_valid,
  output logic [CODE_W-1:0] out_status_code,
  output logic [IDX_W-1:0]  out_word_index,
  output logic [WORD_W-1:0] out_word_value,
  output logic              out_fan_fault,
  output logic              out_fan_speed_fault,
  output logic              out_last_of_run
);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              active_r, active_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic              hdr_bad_r, hdr_bad_nxt;
  logic [BYTE_W-1:0] hold_r, hold_nxt;
  logic              emitting_r, emitting_nxt;
  logic [IDX_W-1:0]  emit_idx_r, emit_idx_nxt;
  logic              fan_r, fan_nxt;
  logic              fspd_r, fspd_nxt;

  logic              valid_r, valid_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [WORD_W-1:0] val_r, val_nxt;
  logic              ofan_r, ofan_nxt;
  logic              ofspd_r, ofspd_nxt;
  logic              last_r, last_nxt;

  logic              accept;
  logic [POS_W-1:0]  p;
  logic [POS_W-1:0]  d_off;
  logic [IDX_W-1:0]  k;
  logic              act;
  logic [BYTE_W-1:0] s;
  logic              bad;
  logic [WORD_W-1:0] head;
  chain_ctl_t        ctl;

  assign accept = start && !busy;
  assign busy   = emitting_r;
  assign p      = in_frame_start ? '0 : pos_r;
  assign act    = in_frame_start || active_r;
  assign s      = in_frame_start ? '0 : sum_r;
  assign bad    = in_frame_start ? 1'b0 : hdr_bad_r;
  assign d_off  = p - POS_W'(2);
  assign k      = d_off[POS_W-1:1];

  always_comb begin
    pos_nxt      = pos_r;
    active_nxt   = active_r;
    sum_nxt      = sum_r;
    hdr_bad_nxt  = hdr_bad_r;
    hold_nxt     = hold_r;
    emitting_nxt = emitting_r;
    emit_idx_nxt = emit_idx_r;
    fan_nxt      = fan_r;
    fspd_nxt     = fspd_r;
    valid_nxt    = 1'b0;
    code_nxt     = ST_OK;
    idx_nxt      = '0;
    val_nxt      = '0;
    ofan_nxt     = 1'b0;
    ofspd_nxt    = 1'b0;
    last_nxt     = 1'b0;
    ctl.shift    = 1'b0;
    ctl.word     = {hold_r, in_rx_byte};

    if (emitting_r) begin
      ctl.shift = 1'b1;
      if (emit_idx_r == '0) begin
        fan_nxt  = head[FAN_BIT];
        fspd_nxt = head[FAN_SPEED_BIT];
      end
      valid_nxt = 1'b1;
      code_nxt  = ST_OK;
      idx_nxt   = emit_idx_r;
      val_nxt   = head;
      ofan_nxt  = fan_nxt;
      ofspd_nxt = fspd_nxt;
      last_nxt  = (emit_idx_r == LAST_IDX);
      emit_idx_nxt = emit_idx_r + IDX_W'(1);
      if (emit_idx_r == LAST_IDX) begin
        emitting_nxt = 1'b0;
      end
    end else if (accept) begin
      pos_nxt     = p;
      active_nxt  = act;
      sum_nxt     = s;
      hdr_bad_nxt = bad;
      if (in_frame_start) begin
        hold_nxt = '0;
      end
      if (act) begin
        if (p < LAST_POS) begin
          sum_nxt = s + in_rx_byte;
          if ((p == POS_W'(0)) && (in_rx_byte != HEAD_BYTE0)) begin
            hdr_bad_nxt = 1'b1;
          end
          if ((p == POS_W'(1)) && (in_rx_byte != HEAD_BYTE1)) begin
            hdr_bad_nxt = 1'b1;
          end
          if (p >= POS_W'(2)) begin
            if (!d_off[0]) begin
              hold_nxt = in_rx_byte;
            end else if (k < STORE_LIM) begin
              ctl.shift = 1'b1;
            end
          end
          pos_nxt = p + POS_W'(1);
        end else begin
          active_nxt = 1'b0;
          pos_nxt    = '0;
          if (bad) begin
            valid_nxt = 1'b1;
            code_nxt  = ST_BAD_HEADER;
            last_nxt  = 1'b1;
          end else if (s != in_rx_byte) begin
            valid_nxt = 1'b1;
            code_nxt  = ST_BAD_SUM;
            last_nxt  = 1'b1;
          end else begin
            emitting_nxt = 1'b1;
            emit_idx_nxt = '0;
          end
        end
      end
    end
  end

  sfc_chain u_chain (
    .clk  (clk),
    .ctl  (ctl),
    .head (head)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      active_r   <= 1'b0;
      sum_r      <= '0;
      hdr_bad_r  <= 1'b0;
      hold_r     <= '0;
      emitting_r <= 1'b0;
      emit_idx_r <= '0;
      valid_r    <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      active_r   <= active_nxt;
      sum_r      <= sum_nxt;
      hdr_bad_r  <= hdr_bad_nxt;
      hold_r     <= hold_nxt;
      emitting_r <= emitting_nxt;
      emit_idx_r <= emit_idx_nxt;
      valid_r    <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fan_r   <= fan_nxt;
    fspd_r  <= fspd_nxt;
    code_r  <= code_nxt;
    idx_r   <= idx_nxt;
    val_r   <= val_nxt;
    ofan_r  <= ofan_nxt;
    ofspd_r <= ofspd_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid           = valid_r;
  assign out_status_code     = code_r;
  assign out_word_index      = idx_r;
  assign out_word_value      = val_r;
  assign out_fan_fault       = ofan_r;
  assign out_fan_speed_fault = ofspd_r;
  assign out_last_of_run     = last_r;

`ifndef NO_ASSERTIONS
  a_err_single : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status_code != ST_OK)) |-> (out_last_of_run && (out_word_index == '0)
      && (out_word_value == '0)))
    else $error("error result is not a single zeroed transaction");

  a_burst_contig : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_of_run) |=> out_valid)
    else $error("word burst broken before its last transaction");

  a_emit_end : assert property (@(posedge clk) disable iff (!rst_n)
    (emitting_r && (emit_idx_r == LAST_IDX)) |=> (!emitting_r && out_last_of_run && out_valid))
    else $error("emission did not end on the last word");

  a_busy_cause : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted byte");
`endif

endmodule
